// ===== design/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the framed 7-to-8 bit decoder
// Holds the framing byte codes and the result record carried between the
// unpacking logic and the output register.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Framing and command codes.
    localparam logic [7:0] START_BYTE = 8'hF0;
    localparam logic [7:0] START_TAG  = 8'h01;
    localparam logic [7:0] END_BYTE   = 8'hF7;
    localparam logic [7:0] HIGH_BIT   = 8'h80;
    localparam logic [7:0] CMD_MULTI_A = 8'h01;
    localparam logic [7:0] CMD_MULTI_B = 8'h03;
    localparam logic [7:0] SUB_MULTI   = 8'h01;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       message_end;
        logic [7:0] command;
        logic [7:0] sub_command;
        logic [7:0] seq_number;
        logic       frame_error;
    } t_result;

endpackage

// ===== design/sfd_unpack.sv =====
// ----------------------------------------------------------------------------
// sfd_unpack: chunk parser and 7-to-8 bit unpacker
// Tracks the header position, payload group position and multi-chunk prefix,
// and forms the result (if any) that the current byte causes.
// ----------------------------------------------------------------------------
module sfd_unpack (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output logic             o_fire,
    output sfd_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        HP_START,
        HP_TAG,
        HP_SEQ,
        HP_UNUSED,
        HP_CMD,
        HP_SUB,
        HP_PAYLOAD
    } t_hdr;

    t_hdr       r_hp,        n_hp;
    logic [2:0] r_group_pos, n_group_pos;
    logic [6:0] r_high_bits, n_high_bits;
    logic [7:0] r_cmd,       n_cmd;
    logic [7:0] r_sub,       n_sub;
    logic [7:0] r_seq,       n_seq;
    logic [1:0] r_prefix,    n_prefix;
    logic [7:0] r_total,     n_total;
    logic [7:0] r_index,     n_index;
    logic       r_discard,   n_discard;

    logic       is_end;
    logic       is_multi;
    logic [7:0] data_byte;
    logic       last_chunk;

    assign is_end   = (i_byte == sfd_pkg::END_BYTE);
    assign is_multi = ((r_cmd == sfd_pkg::CMD_MULTI_A) || (r_cmd == sfd_pkg::CMD_MULTI_B))
                      && (r_sub == sfd_pkg::SUB_MULTI);
    assign data_byte = r_high_bits[r_group_pos - 3'd1] ? (i_byte | sfd_pkg::HIGH_BIT)
                                                         : i_byte;
    assign last_chunk = (r_prefix >= 2'd2)
                        && (({1'b0, r_index} + 9'd1) == {1'b0, r_total});

    always_comb begin
        n_hp        = r_hp;
        n_group_pos = r_group_pos;
        n_high_bits = r_high_bits;
        n_cmd       = r_cmd;
        n_sub       = r_sub;
        n_seq       = r_seq;
        n_prefix    = r_prefix;
        n_total     = r_total;
        n_index     = r_index;
        n_discard   = r_discard;

        o_fire            = 1'b0;
        o_res.out_byte    = 8'h00;
        o_res.byte_valid  = 1'b0;
        o_res.message_end = 1'b0;
        o_res.command     = r_cmd;
        o_res.sub_command = r_sub;
        o_res.seq_number  = r_seq;
        o_res.frame_error = 1'b0;

        if (r_discard) begin
            if (is_end) begin
                n_discard = 1'b0;
                n_hp      = HP_START;
            end
        end else begin
            unique case (r_hp)
                HP_START, HP_TAG: begin
                    if (i_byte == ((r_hp == HP_START) ? sfd_pkg::START_BYTE
                                                       : sfd_pkg::START_TAG)) begin
                        n_hp = (r_hp == HP_START) ? HP_TAG : HP_SEQ;
                    end else begin
                        n_hp              = HP_START;
                        n_discard         = !is_end;
                        o_fire            = 1'b1;
                        o_res.frame_error = 1'b1;
                    end
                end
                HP_SEQ: begin
                    if (is_end) begin
                        n_hp = HP_START;
                    end else begin
                        n_seq = i_byte;
                        n_hp  = HP_UNUSED;
                    end
                end
                HP_UNUSED: begin
                    n_hp = is_end ? HP_START : HP_CMD;
                end
                HP_CMD: begin
                    if (is_end) begin
                        n_hp = HP_START;
                    end else begin
                        n_cmd = i_byte;
                        n_hp  = HP_SUB;
                    end
                end
                HP_SUB: begin
                    if (is_end) begin
                        n_hp = HP_START;
                    end else begin
                        n_sub       = i_byte;
                        n_group_pos = 3'd0;
                        n_high_bits = 7'd0;
                        n_prefix    = 2'd0;
                        n_hp        = HP_PAYLOAD;
                    end
                end
                HP_PAYLOAD: begin
                    if (is_end) begin
                        // End of chunk; a multi-chunk message ends only on its last chunk.
                        n_hp        = HP_START;
                        n_group_pos = 3'd0;
                        if (!is_multi || last_chunk) begin
                            o_fire            = 1'b1;
                            o_res.message_end = 1'b1;
                        end
                    end else if (r_group_pos == 3'd0) begin
                        n_high_bits = i_byte[6:0];
                        n_group_pos = 3'd1;
                    end else begin
                        n_group_pos = (r_group_pos == 3'd7) ? 3'd0 : (r_group_pos + 3'd1);
                        if (is_multi && (r_prefix != 2'd3)) begin
                            // Count, index and spare byte are swallowed.
                            if (r_prefix == 2'd0) begin
                                n_total = data_byte;
                            end else if (r_prefix == 2'd1) begin
                                n_index = data_byte;
                            end
                            n_prefix = r_prefix + 2'd1;
                        end else begin
                            o_fire           = 1'b1;
                            o_res.out_byte   = data_byte;
                            o_res.byte_valid = 1'b1;
                        end
                    end
                end
                default: begin
                    n_hp = HP_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp        <= HP_START;
            r_group_pos <= 3'd0;
            r_high_bits <= 7'd0;
            r_cmd       <= 8'h00;
            r_sub       <= 8'h00;
            r_seq       <= 8'h00;
            r_prefix    <= 2'd0;
            r_total     <= 8'h00;
            r_index     <= 8'h00;
            r_discard   <= 1'b0;
        end else if (i_take) begin
            r_hp        <= n_hp;
            r_group_pos <= n_group_pos;
            r_high_bits <= n_high_bits;
            r_cmd       <= n_cmd;
            r_sub       <= n_sub;
            r_seq       <= n_seq;
            r_prefix    <= n_prefix;
            r_total     <= n_total;
            r_index     <= n_index;
            r_discard   <= n_discard;
        end
    end

endmodule

// ===== design/sfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// sfd_out_reg: result register of the decoder
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module sfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sfd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output sfd_pkg::t_result o_res
);

    logic             r_valid;
    sfd_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Data needs no reset; it is only looked at while r_valid is set.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== design/sysex_frame_7to8_decoder_top.sv =====
// ----------------------------------------------------------------------------
// sysex_frame_7to8_decoder_top: framed 7-bit chunk to 8-bit byte decoder
// Parses F0 01 framed chunks, unpacks 7-bit payload groups into 8-bit bytes
// and reports message ends, reassembling multi-chunk messages.
// ----------------------------------------------------------------------------
// Usage:
// Raw stream bytes arrive one per request on the input channel
// (i_in_valid / o_in_ready / i_in_byte). Each byte causes zero or one result
// request on the output channel (o_out_valid / i_out_ready), which carries a
// decoded byte, an end-of-message mark or a framing error, together with the
// command, subcommand and sequence number of the current chunk.
// The result of an accepted byte is registered and is on the ports in the
// cycle after the byte is accepted. Throughput is one byte per cycle while
// the receiver does not stall; the parse state and the result register are
// both updated at the accepting edge, so the rate is set by that single register stage.
// The block keeps taking bytes while a result waits, as long as the waiting
// result is taken in the same cycle; when the receiver stalls with a result
// held, o_in_ready drops until it is taken. Bytes that produce no result
// (header bytes, flag bytes, swallowed prefix bytes) still need a free or
// draining result register.
// Reset (synchronous, active low) returns the parser to expecting a start
// byte, clears the held header fields and empties the result register.
// ----------------------------------------------------------------------------
module sysex_frame_7to8_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_message_end,
    output logic [7:0] o_command,
    output logic [7:0] o_sub_command,
    output logic [7:0] o_seq_number,
    output logic       o_frame_error
);

    logic             take;
    logic             fire;
    sfd_pkg::t_result step_res;
    sfd_pkg::t_result out_res;

    // Room exists when the result register is empty or is being emptied now.
    assign o_in_ready = !o_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    sfd_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in_byte),
        .o_fire  (fire),
        .o_res   (step_res)
    );

    sfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && fire),
        .i_res   (step_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_out_byte    = out_res.out_byte;
    assign o_byte_valid  = out_res.byte_valid;
    assign o_message_end = out_res.message_end;
    assign o_command     = out_res.command;
    assign o_sub_command = out_res.sub_command;
    assign o_seq_number  = out_res.seq_number;
    assign o_frame_error = out_res.frame_error;

    // A result is exactly one kind: data byte, message end or framing error.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot({o_byte_valid, o_message_end, o_frame_error}))
        else $error("result carries more or less than one kind");

    // Non-data results carry a zero byte.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_out_byte == 8'h00))
        else $error("non-data result with nonzero byte");

    // A held result blocks the input side.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result stalled");

    // A stalled result is never overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(out_res)))
        else $error("stalled result changed");

endmodule
